// ===== rtl/mhsi_pkg.sv =====
package mhsi_pkg;

  localparam int unsigned HartW     = 2;
  localparam int unsigned HartSlots = 4;
  localparam int unsigned RegW      = 5;
  localparam int unsigned RegCount  = 32;
  localparam int unsigned PcFieldW  = 16;
  localparam int unsigned PlFieldW  = 48;
  localparam int unsigned FlagW     = 3;
  localparam int unsigned MaskW     = 4;

  // bit positions in the flags field
  localparam int unsigned FlagSrc1 = 0;
  localparam int unsigned FlagSrc2 = 1;
  localparam int unsigned FlagDest = 2;

  typedef struct packed {
    logic                in_valid;
    logic [HartW-1:0]    in_hart;
    logic [PcFieldW-1:0] in_fetch_pc;
    logic [RegW-1:0]     in_src1;
    logic [RegW-1:0]     in_src2;
    logic [RegW-1:0]     in_dest;
    logic [FlagW-1:0]    in_flags;
    logic [PlFieldW-1:0] in_payload;
    logic [MaskW-1:0]    exec_full_mask;
    logic                wb_valid;
    logic [HartW-1:0]    wb_hart;
    logic [RegW-1:0]     wb_reg;
  } in_beat_t;

  typedef struct packed {
    logic                issue_valid;
    logic [HartW-1:0]    issue_hart;
    logic [PcFieldW-1:0] issue_fetch_pc;
    logic [RegW-1:0]     issue_src1;
    logic [RegW-1:0]     issue_src2;
    logic [RegW-1:0]     issue_dest;
    logic [FlagW-1:0]    issue_flags;
    logic [PlFieldW-1:0] issue_payload;
    logic                lock_valid;
  } out_beat_t;

endpackage

// ===== rtl/multihart_scoreboard_issue_core.sv =====
// channel | handshake                  | payload
// --------+----------------------------+-----------------------
// input   | in_valid_i / in_ready_o    | in_data_i  (in_beat_t)
// output  | out_valid_o / out_ready_i  | out_data_o (out_beat_t)
//
// one result beat per input beat; a beat is taken every cycle unless the output
// register stalls; its result shows on the next cycle from the output register
// hazard check, lowest-hart pick and scoreboard update sit in one combinational
// pass between the state registers and the output register
// in_ready_o is low only while the output register holds a beat that is stalled
// reset empties all slots and clears all busy bits; held slot contents need none
module multihart_scoreboard_issue_core #(
  parameter int unsigned HARTS        = 4,
  parameter int unsigned REGISTERS    = 32,
  parameter int unsigned PC_BITS      = 16,
  parameter int unsigned PAYLOAD_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhsi_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mhsi_pkg::out_beat_t out_data_o
);
  import mhsi_pkg::*;

  // harts and registers beyond what the fields can name never get used
  localparam int unsigned NumHarts = (HARTS < HartSlots) ? HARTS : HartSlots;
  localparam int unsigned NumRegs  = (REGISTERS < RegCount) ? REGISTERS : RegCount;
  localparam int unsigned PcW      = (PC_BITS < PcFieldW) ? PC_BITS : PcFieldW;
  localparam int unsigned PlW      = (PAYLOAD_BITS < PlFieldW) ? PAYLOAD_BITS : PlFieldW;

  typedef logic [NumRegs-1:0] busy_t;

  typedef struct packed {
    logic [PcW-1:0]   pc;
    logic [RegW-1:0]  src1;
    logic [RegW-1:0]  src2;
    logic [RegW-1:0]  dest;
    logic [FlagW-1:0] flags;
    logic [PlW-1:0]   payload;
  } held_t;

  // shifts out to zero for a register number at or above NumRegs
  function automatic busy_t reg_bit(logic [RegW-1:0] r);
    reg_bit = busy_t'(1'b1) << r;
  endfunction

  function automatic logic must_wait(busy_t busy, held_t ins);
    must_wait = (ins.flags[FlagSrc1] && |(busy & reg_bit(ins.src1))) ||
                (ins.flags[FlagSrc2] && |(busy & reg_bit(ins.src2)));
  endfunction

  logic [NumHarts-1:0] slot_full_q, slot_full_d;
  held_t               held_q [NumHarts];
  busy_t               busy_q [NumHarts];
  busy_t               busy_d [NumHarts];
  logic                out_valid_q;
  out_beat_t           out_q, out_d;

  logic [NumHarts-1:0] held_ready, sel_oh, arrive_oh, wb_oh, issue_oh;
  logic                sel, arrive, direct, issuing, lock, found;
  busy_t               in_busy;
  held_t               held_in, iss;
  logic [HartW-1:0]    iss_hart;
  logic                in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    held_in.pc      = in_data_i.in_fetch_pc[PcW-1:0];
    held_in.src1    = in_data_i.in_src1;
    held_in.src2    = in_data_i.in_src2;
    held_in.dest    = in_data_i.in_dest;
    held_in.flags   = in_data_i.in_flags;
    held_in.payload = in_data_i.in_payload[PlW-1:0];

    // ready held slots against the busy bits before this beat
    found   = 1'b0;
    sel_oh  = '0;
    in_busy = '0;
    for (int unsigned h = 0; h < NumHarts; h++) begin
      held_ready[h] = slot_full_q[h] && !in_data_i.exec_full_mask[h] &&
                      !must_wait(busy_q[h], held_q[h]);
      if (held_ready[h] && !found) begin
        sel_oh[h] = 1'b1;
        found     = 1'b1;
      end
      arrive_oh[h] = in_data_i.in_valid && (in_data_i.in_hart == HartW'(h));
      wb_oh[h]     = in_data_i.wb_valid && (in_data_i.wb_hart == HartW'(h));
      if (arrive_oh[h]) in_busy = busy_q[h];
    end
    sel    = found;
    arrive = |arrive_oh;
    direct = arrive && !in_data_i.exec_full_mask[in_data_i.in_hart] &&
             !must_wait(in_busy, held_in);

    issuing  = sel || direct;
    issue_oh = sel ? sel_oh : (direct ? arrive_oh : '0);

    // an arrival overwrites its slot, so a pick of that hart sends the new one
    iss      = '0;
    iss_hart = '0;
    for (int unsigned h = 0; h < NumHarts; h++) begin
      if (issue_oh[h]) begin
        iss      = arrive_oh[h] ? held_in : held_q[h];
        iss_hart = HartW'(h);
      end
    end
    lock = issuing && iss.flags[FlagDest];

    slot_full_d = (slot_full_q | arrive_oh) & ~issue_oh;
    // writeback clear first, then the lock set
    for (int unsigned h = 0; h < NumHarts; h++) begin
      busy_d[h] = (busy_q[h] & ~(wb_oh[h] ? reg_bit(in_data_i.wb_reg) : busy_t'(0))) |
                  ((issue_oh[h] && lock) ? reg_bit(iss.dest) : busy_t'(0));
    end

    out_d                = '0;
    out_d.issue_valid    = issuing;
    out_d.issue_hart     = iss_hart;
    out_d.issue_fetch_pc = PcFieldW'(iss.pc);
    out_d.issue_src1     = iss.src1;
    out_d.issue_src2     = iss.src2;
    out_d.issue_dest     = iss.dest;
    out_d.issue_flags    = iss.flags;
    out_d.issue_payload  = PlFieldW'(iss.payload);
    out_d.lock_valid     = lock;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_full_q <= '0;
      out_valid_q <= 1'b0;
      for (int unsigned h = 0; h < NumHarts; h++) busy_q[h] <= '0;
    end else begin
      if (in_fire) begin
        slot_full_q <= slot_full_d;
        out_valid_q <= 1'b1;
        for (int unsigned h = 0; h < NumHarts; h++) busy_q[h] <= busy_d[h];
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
      for (int unsigned h = 0; h < NumHarts; h++) begin
        if (arrive_oh[h]) held_q[h] <= held_in;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/mhsi_checker.sv =====
module mhsi_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mhsi_pkg::out_beat_t out_data_o
);
  import mhsi_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // every accepted beat gives a result beat on the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // an empty output register never back-pressures the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_lock_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.lock_valid |-> out_data_o.issue_valid)
    else $error("lock without issue");

  // no issue means an all-zero result
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.issue_valid |-> out_data_o == '0)
    else $error("nonzero fields on a result without issue");

endmodule

bind multihart_scoreboard_issue_core mhsi_checker u_checker (.*);
